[rtl/dlle_pkg.sv]
// Shared constants, codes and widths for the doubly linked list engine.
package dlle_pkg;

  localparam int DEF_CAPACITY   = 32;
  localparam int DEF_DATA_WIDTH = 32;
  localparam int OUT_LIMIT      = 32;

  localparam int KIND_W   = 4;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 3;

  // request kinds
  localparam logic [KIND_W-1:0] K_INS_F  = 4'd0;
  localparam logic [KIND_W-1:0] K_INS_B  = 4'd1;
  localparam logic [KIND_W-1:0] K_INS_P  = 4'd2;
  localparam logic [KIND_W-1:0] K_DEL_F  = 4'd3;
  localparam logic [KIND_W-1:0] K_DEL_B  = 4'd4;
  localparam logic [KIND_W-1:0] K_DEL_P  = 4'd5;
  localparam logic [KIND_W-1:0] K_SRCH   = 4'd6;
  localparam logic [KIND_W-1:0] K_DUMP_F = 4'd7;
  localparam logic [KIND_W-1:0] K_DUMP_R = 4'd8;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd4;

  typedef enum logic [1:0] {
    OP_INS  = 2'd0,
    OP_DEL  = 2'd1,
    OP_SRCH = 2'd2,
    OP_DUMP = 2'd3
  } op_t;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_WALK   = 7'b0000010,
    S_INS2   = 7'b0000100,
    S_SRCH   = 7'b0001000,
    S_DSTART = 7'b0010000,
    S_DUMP   = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

endpackage

[rtl/doubly_linked_list_engine.sv]
// Doubly linked circular list engine: sequencer around node and free-stack memories.
// Error results go to the output without a walk; inserts and deletes first walk to their
// position, and an insert into a non-empty list takes one more splice step; search walks
// until the first match or the list end; dump emits elements in turn, up to OUT_LIMIT.
// One request at a time: a request is taken only in idle. The link walk reads one node
// per cycle; a dump holds its walk while the output channel is stalled.
// Reset (synchronous, rst_n low): list empty, free stack full, output channel idle;
// node memories hold no reset value and are only read through valid links.
module doubly_linked_list_engine #(
  parameter int CAPACITY   = dlle_pkg::DEF_CAPACITY,
  parameter int DATA_WIDTH = dlle_pkg::DEF_DATA_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [dlle_pkg::KIND_W-1:0]           in_kind,
  input  logic signed [dlle_pkg::VALUE_W-1:0]   in_value,
  input  logic [dlle_pkg::POS_W-1:0]            in_position,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [dlle_pkg::STATUS_W-1:0]         out_status,
  output logic signed [dlle_pkg::VALUE_W-1:0]   out_value_res,
  output logic [dlle_pkg::POS_W-1:0]            out_found_position,
  output logic                                  out_last
);
  import dlle_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = (CW > 7) ? CW : 7;
  localparam int DW = DATA_WIDTH;

  // Node memories: data, forward link, backward link (one read port, one write port each)
  logic [DW-1:0] nd_mem [CAPACITY];
  logic [AW-1:0] nx_mem [CAPACITY];
  logic [AW-1:0] pv_mem [CAPACITY];
  // Free stack; entries never written read as their own index
  logic [AW-1:0] fs_mem [CAPACITY];
  logic [CAPACITY-1:0] fs_v_r;

  logic [DW-1:0] dat_q;
  logic [AW-1:0] nxt_q, prv_q, fs_q;

  logic [AW-1:0] ra, fs_ra;
  logic          nd_we, nx_we, pv_we, fs_we;
  logic [AW-1:0] nd_wa, nx_wa, pv_wa, fs_wa;
  logic [DW-1:0] nd_wd;
  logic [AW-1:0] nx_wd, pv_wd, fs_wd;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic   rev_r, rev_nxt, front_r, front_nxt;
  logic [DW-1:0] data_r, data_nxt;
  logic [AW-1:0] p_r, p_nxt, n_r, n_nxt, bef_r, bef_nxt, head_r, head_nxt;
  logic [CW-1:0] ctr_r, ctr_nxt, idx_r, idx_nxt, lim_r, lim_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, fcnt_r, fcnt_nxt;
  logic [STATUS_W-1:0] res_st_r, res_st_nxt;
  logic [VALUE_W-1:0]  res_val_r, res_val_nxt;
  logic [POS_W-1:0]    res_fp_r, res_fp_nxt;
  logic                out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [STATUS_W-1:0] out_st_r, out_st_nxt;
  logic [VALUE_W-1:0]  out_val_r, out_val_nxt;
  logic [POS_W-1:0]    out_fp_r, out_fp_nxt;

  logic          slot_free;
  logic [KW-1:0] pos_k, cnt_k, p_k;
  logic [AW-1:0] step_addr;

  assign in_ready           = (state_r == S_IDLE);
  assign slot_free          = !out_valid_r || out_ready;
  assign out_valid          = out_valid_r;
  assign out_status         = out_st_r;
  assign out_value_res      = out_val_r;
  assign out_found_position = out_fp_r;
  assign out_last           = out_last_r;

  assign pos_k = KW'(in_position);
  assign cnt_k = KW'(cnt_r);
  assign fs_ra = AW'(fcnt_r - 1'b1);
  assign step_addr = rev_r ? prv_q : nxt_q;

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    rev_nxt     = rev_r;
    front_nxt   = front_r;
    data_nxt    = data_r;
    p_nxt       = p_r;
    n_nxt       = n_r;
    bef_nxt     = bef_r;
    head_nxt    = head_r;
    ctr_nxt     = ctr_r;
    idx_nxt     = idx_r;
    lim_nxt     = lim_r;
    cnt_nxt     = cnt_r;
    fcnt_nxt    = fcnt_r;
    res_st_nxt  = res_st_r;
    res_val_nxt = res_val_r;
    res_fp_nxt  = res_fp_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_st_nxt    = out_st_r;
    out_val_nxt   = out_val_r;
    out_fp_nxt    = out_fp_r;
    out_last_nxt  = out_last_r;
    ra    = p_r;
    nd_we = 1'b0; nd_wa = n_r; nd_wd = data_r;
    nx_we = 1'b0; nx_wa = n_r; nx_wd = p_r;
    pv_we = 1'b0; pv_wa = n_r; pv_wd = p_r;
    fs_we = 1'b0; fs_wa = AW'(fcnt_r); fs_wd = p_r;
    p_k   = pos_k;

    unique case (state_r)
      S_IDLE: begin
        // read the head node so a walk can start next cycle
        ra = head_r;
        if (in_valid) begin
          p_nxt       = head_r;
          data_nxt    = DW'(in_value);
          res_val_nxt = '0;
          res_fp_nxt  = '0;
          idx_nxt     = CW'(1);
          unique case (in_kind) inside
            K_INS_F, K_INS_B, K_INS_P: begin
              if (in_kind == K_INS_F) p_k = KW'(1);
              else if (in_kind == K_INS_B) p_k = cnt_k + KW'(1);
              op_nxt    = OP_INS;
              front_nxt = (p_k == KW'(1));
              ctr_nxt   = (p_k == cnt_k + KW'(1)) ? '0 : CW'(p_k - KW'(1));
              if (cnt_r == CW'(CAPACITY)) begin
                res_st_nxt = ST_FULL;
                state_nxt  = S_EMIT;
              end else if (p_k == '0 || p_k > cnt_k + KW'(1)) begin
                res_st_nxt = ST_BADPOS;
                state_nxt  = S_EMIT;
              end else begin
                state_nxt = S_WALK;
              end
            end
            K_DEL_F, K_DEL_B, K_DEL_P: begin
              if (in_kind == K_DEL_F) p_k = KW'(1);
              else if (in_kind == K_DEL_B) p_k = cnt_k;
              op_nxt    = OP_DEL;
              front_nxt = (p_k == KW'(1));
              ctr_nxt   = CW'(p_k - KW'(1));
              if (cnt_r == '0) begin
                res_st_nxt = ST_EMPTY;
                state_nxt  = S_EMIT;
              end else if (p_k == '0 || p_k > cnt_k) begin
                res_st_nxt = ST_BADPOS;
                state_nxt  = S_EMIT;
              end else begin
                state_nxt = S_WALK;
              end
            end
            K_SRCH: begin
              op_nxt = OP_SRCH;
              if (cnt_r == '0) begin
                res_st_nxt = ST_EMPTY;
                state_nxt  = S_EMIT;
              end else begin
                state_nxt = S_SRCH;
              end
            end
            K_DUMP_F, K_DUMP_R: begin
              op_nxt  = OP_DUMP;
              rev_nxt = (in_kind == K_DUMP_R);
              lim_nxt = (cnt_k < KW'(OUT_LIMIT)) ? cnt_r : CW'(OUT_LIMIT);
              if (cnt_r == '0) begin
                res_st_nxt = ST_EMPTY;
                state_nxt  = S_EMIT;
              end else begin
                state_nxt = S_DSTART;
              end
            end
            default: ;
          endcase
        end
      end

      S_WALK: begin
        if (ctr_r != '0) begin
          // advance one node per cycle
          ra      = nxt_q;
          p_nxt   = nxt_q;
          ctr_nxt = ctr_r - 1'b1;
        end else if (op_r == OP_INS) begin
          // pop and fill a free node; splice before the target next cycle if non-empty
          n_nxt    = fs_q;
          fcnt_nxt = fcnt_r - 1'b1;
          nd_we = 1'b1; nd_wa = fs_q; nd_wd = data_r;
          nx_we = 1'b1; nx_wa = fs_q;
          pv_we = 1'b1; pv_wa = fs_q;
          res_st_nxt = ST_OK;
          if (cnt_r == '0) begin
            nx_wd     = fs_q;
            pv_wd     = fs_q;
            head_nxt  = fs_q;
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = S_EMIT;
          end else begin
            nx_wd     = p_r;
            pv_wd     = prv_q;
            bef_nxt   = prv_q;
            state_nxt = S_INS2;
          end
        end else begin
          // unlink the node and push it on the free stack
          res_val_nxt = VALUE_W'(signed'(dat_q));
          res_st_nxt  = ST_OK;
          if (cnt_r == CW'(1)) begin
            head_nxt = '0;
          end else begin
            nx_we = 1'b1; nx_wa = prv_q; nx_wd = nxt_q;
            pv_we = 1'b1; pv_wa = nxt_q; pv_wd = prv_q;
            if (front_r) head_nxt = nxt_q;
          end
          cnt_nxt = cnt_r - 1'b1;
          if (fcnt_r < CW'(CAPACITY)) begin
            fs_we    = 1'b1;
            fcnt_nxt = fcnt_r + 1'b1;
          end
          state_nxt = S_EMIT;
        end
      end

      S_INS2: begin
        nx_we = 1'b1; nx_wa = bef_r; nx_wd = n_r;
        pv_we = 1'b1; pv_wa = p_r;   pv_wd = n_r;
        if (front_r) head_nxt = n_r;
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = S_EMIT;
      end

      S_SRCH: begin
        if (dat_q == data_r) begin
          res_st_nxt = ST_OK;
          res_fp_nxt = POS_W'(idx_r);
          state_nxt  = S_EMIT;
        end else if (idx_r == cnt_r) begin
          res_st_nxt = ST_NOTFOUND;
          state_nxt  = S_EMIT;
        end else begin
          ra      = nxt_q;
          p_nxt   = nxt_q;
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_DSTART: begin
        // reverse dump starts at the tail
        if (rev_r) begin
          ra    = prv_q;
          p_nxt = prv_q;
        end
        state_nxt = S_DUMP;
      end

      S_DUMP: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = ST_OK;
          out_val_nxt   = VALUE_W'(signed'(dat_q));
          out_fp_nxt    = '0;
          out_last_nxt  = (idx_r == lim_r);
          if (idx_r == lim_r) begin
            state_nxt = S_IDLE;
          end else begin
            ra      = step_addr;
            p_nxt   = step_addr;
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_val_nxt   = res_val_r;
          out_fp_nxt    = res_fp_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Memories: registered read, write port per array
  always_ff @(posedge clk) begin
    dat_q <= nd_mem[ra];
    nxt_q <= nx_mem[ra];
    prv_q <= pv_mem[ra];
    fs_q  <= fs_v_r[fs_ra] ? fs_mem[fs_ra] : fs_ra;
    if (nd_we) nd_mem[nd_wa] <= nd_wd;
    if (nx_we) nx_mem[nx_wa] <= nx_wd;
    if (pv_we) pv_mem[pv_wa] <= pv_wd;
    if (fs_we) fs_mem[fs_wa] <= fs_wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      fcnt_r      <= CW'(CAPACITY);
      fs_v_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      fcnt_r      <= fcnt_nxt;
      if (fs_we) fs_v_r[fs_wa] <= 1'b1;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    rev_r     <= rev_nxt;
    front_r   <= front_nxt;
    data_r    <= data_nxt;
    p_r       <= p_nxt;
    n_r       <= n_nxt;
    bef_r     <= bef_nxt;
    ctr_r     <= ctr_nxt;
    idx_r     <= idx_nxt;
    lim_r     <= lim_nxt;
    res_st_r  <= res_st_nxt;
    res_val_r <= res_val_nxt;
    res_fp_r  <= res_fp_nxt;
    out_st_r  <= out_st_nxt;
    out_val_r <= out_val_nxt;
    out_fp_r  <= out_fp_nxt;
    out_last_r <= out_last_nxt;
  end

  // every node is either on the list or on the free stack; a node popped for a
  // splice is counted on the list in the next cycle, so the check skips S_INS2
  a_node_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS2) || ((KW'(cnt_r) + KW'(fcnt_r)) == KW'(CAPACITY)))
    else $error("list and free stack sizes disagree");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_err_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_st_r != ST_OK) |-> (out_val_r == '0) && out_last_r)
    else $error("error result carries data or is not final");

  a_walk_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (cnt_r == '0) |=> (state_r != S_SRCH) && (state_r != S_DSTART))
    else $error("walk started on an empty list");

endmodule

[tb/testbench.sv]
// Self-checking testbench for the doubly linked list engine.
module testbench;
  import dlle_pkg::*;

  localparam int CAP = 32;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0] position;
  } list_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic signed [VALUE_W-1:0] value_res;
    logic [POS_W-1:0] found_position;
    logic last;
  } list_rsp_t;

  // Directed row: request plus an optional typed-in answer (first result only).
  typedef struct {
    list_req_t req;
    logic has_exp;
    logic [STATUS_W-1:0] exp_status;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [KIND_W-1:0] in_kind = '0;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic [POS_W-1:0] in_position = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic signed [VALUE_W-1:0] out_value_res;
  logic [POS_W-1:0] out_found_position;
  logic out_last;

  doubly_linked_list_engine i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_kind(in_kind), .in_value(in_value), .in_position(in_position),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_value_res(out_value_res),
    .out_found_position(out_found_position), .out_last(out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow list: an ordered queue of stored values is enough to predict
  // every answer, since node indexes never show at the outputs.
  logic signed [VALUE_W-1:0] shadow_list[$];
  list_rsp_t pending_rsp[$];
  list_rsp_t typed_rsp[$];
  int mismatch_count = 0;
  int req_count = 0;
  int rsp_count = 0;
  bit quiet_phase = 1'b0;
  bit hold_off_req = 1'b0;

  function automatic list_rsp_t mk_rsp(logic [STATUS_W-1:0] st,
                                       logic signed [VALUE_W-1:0] v,
                                       logic [POS_W-1:0] fp, logic lst);
    list_rsp_t r;
    r.status = st; r.value_res = v; r.found_position = fp; r.last = lst;
    return r;
  endfunction

  // Apply one request to the shadow list and queue what it should produce.
  task automatic predict_list_op(list_req_t rq);
    int n;
    int p;
    logic signed [VALUE_W-1:0] v;
    n = shadow_list.size();
    case (rq.kind)
      K_INS_F, K_INS_B, K_INS_P: begin
        p = (rq.kind == K_INS_F) ? 1 : (rq.kind == K_INS_B) ? n + 1 : int'(rq.position);
        if (n >= CAP) pending_rsp.push_back(mk_rsp(ST_FULL, 0, 0, 1));
        else if (p < 1 || p > n + 1) pending_rsp.push_back(mk_rsp(ST_BADPOS, 0, 0, 1));
        else begin
          shadow_list.insert(p - 1, rq.value);
          pending_rsp.push_back(mk_rsp(ST_OK, 0, 0, 1));
        end
      end
      K_DEL_F, K_DEL_B, K_DEL_P: begin
        p = (rq.kind == K_DEL_F) ? 1 : (rq.kind == K_DEL_B) ? n : int'(rq.position);
        if (n == 0) pending_rsp.push_back(mk_rsp(ST_EMPTY, 0, 0, 1));
        else if (p < 1 || p > n) pending_rsp.push_back(mk_rsp(ST_BADPOS, 0, 0, 1));
        else begin
          v = shadow_list[p - 1];
          shadow_list.delete(p - 1);
          pending_rsp.push_back(mk_rsp(ST_OK, v, 0, 1));
        end
      end
      K_SRCH: begin
        if (n == 0) pending_rsp.push_back(mk_rsp(ST_EMPTY, 0, 0, 1));
        else begin
          p = 0;
          for (int i = 0; i < n; i++)
            if (p == 0 && shadow_list[i] == rq.value) p = i + 1;
          if (p == 0) pending_rsp.push_back(mk_rsp(ST_NOTFOUND, 0, 0, 1));
          else pending_rsp.push_back(mk_rsp(ST_OK, 0, p[POS_W-1:0], 1));
        end
      end
      K_DUMP_F, K_DUMP_R: begin
        if (n == 0) pending_rsp.push_back(mk_rsp(ST_EMPTY, 0, 0, 1));
        else
          for (int i = 0; i < n; i++)
            pending_rsp.push_back(mk_rsp(ST_OK,
              (rq.kind == K_DUMP_F) ? shadow_list[i] : shadow_list[n - 1 - i],
              0, i == n - 1));
      end
      default: ;  // unused kinds produce nothing
    endcase
  endtask

  // Drive one request at the falling edge and hold it until accepted; valid
  // stays high afterwards so back-to-back requests need no extra edge.
  task automatic send_request(list_req_t rq, bit allow_gap);
    if (allow_gap && !quiet_phase && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= rq.kind;
    in_value <= rq.value;
    in_position <= rq.position;
    do @(posedge clk); while (!in_ready);
    predict_list_op(rq);
    req_count++;
    @(negedge clk);
  endtask

  function automatic list_req_t mk_req(logic [KIND_W-1:0] k,
                                       logic signed [VALUE_W-1:0] v,
                                       logic [POS_W-1:0] p);
    list_req_t r;
    r.kind = k; r.value = v; r.position = p;
    return r;
  endfunction

  function automatic list_req_t rand_req();
    list_req_t r;
    int n;
    int roll;
    n = shadow_list.size();
    roll = $urandom_range(0, 99);
    r.value = $urandom();
    // Keep values from a small pool now and then so searches hit.
    if ($urandom_range(0, 1) == 0) r.value = $urandom_range(0, 7);
    if (roll < 5) r.position = POS_W'($urandom());
    else r.position = POS_W'($urandom_range(1, n + 2));
    // Lean toward inserts while the list is short, deletes, searches and dumps when long.
    if (roll < 3) r.kind = KIND_W'($urandom_range(9, 15));
    else if ($urandom_range(0, CAP) >= n) r.kind = KIND_W'($urandom_range(K_INS_F, K_INS_P));
    else r.kind = KIND_W'($urandom_range(K_DEL_F, K_DUMP_R));
    return r;
  endfunction

  // Receiver: random ready bursts, plus one long hold-off on request.
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (200) @(negedge clk);
        hold_off_req = 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        gap = $urandom_range(1, 15);
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest pending one.
  always @(posedge clk) begin
    list_rsp_t want;
    list_rsp_t got;
    if (rst_n && out_valid && out_ready) begin
      got = mk_rsp(out_status, out_value_res, out_found_position, out_last);
      rsp_count++;
      if (pending_rsp.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result st=%0d", got.status);
      end else begin
        want = pending_rsp.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp st=%0d v=%0d fp=%0d l=%0b got st=%0d v=%0d fp=%0d l=%0b",
                     want.status, want.value_res, want.found_position, want.last,
                     got.status, got.value_res, got.found_position, got.last);
        end
        if (typed_rsp.size() != 0) begin
          if (got.status !== typed_rsp[0].status) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch vs table: exp st=%0d got st=%0d",
                       typed_rsp[0].status, got.status);
          end
          void'(typed_rsp.pop_front());
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    dir_row_t dir_rows[$];
    list_req_t rq;
    int wait_cycles;
    // Directed table: empty-list errors, extremes, every kind, bad positions.
    dir_rows = '{
      '{mk_req(K_DEL_F, 0, 1), 1'b1, ST_EMPTY},
      '{mk_req(K_DEL_P, 0, 1), 1'b1, ST_EMPTY},
      '{mk_req(K_SRCH, 5, 1), 1'b1, ST_EMPTY},
      '{mk_req(K_DUMP_F, 0, 1), 1'b1, ST_EMPTY},
      '{mk_req(K_DUMP_R, 0, 1), 1'b1, ST_EMPTY},
      '{mk_req(K_INS_P, 1, 0), 1'b1, ST_BADPOS},
      '{mk_req(K_INS_P, 1, 2), 1'b1, ST_BADPOS},
      '{mk_req(K_INS_P, 32'sh7fffffff, 1), 1'b1, ST_OK},
      '{mk_req(K_DEL_F, 0, 1), 1'b0, ST_OK},
      '{mk_req(K_INS_F, 32'sh80000000, 1), 1'b1, ST_OK},
      '{mk_req(K_INS_B, -1, 1), 1'b1, ST_OK},
      '{mk_req(K_INS_P, 7, 2), 1'b0, ST_OK},
      '{mk_req(K_INS_P, 9, 4), 1'b0, ST_OK},
      '{mk_req(K_INS_P, 9, 6), 1'b1, ST_BADPOS},
      '{mk_req(K_SRCH, 9, 1), 1'b0, ST_OK},
      '{mk_req(K_SRCH, 123, 1), 1'b1, ST_NOTFOUND},
      '{mk_req(K_DUMP_F, 0, 1), 1'b0, ST_OK},
      '{mk_req(K_DUMP_R, 0, 1), 1'b0, ST_OK},
      '{mk_req(K_DEL_P, 0, 5), 1'b1, ST_BADPOS},
      '{mk_req(K_DEL_P, 0, 63), 1'b1, ST_BADPOS},
      '{mk_req(4'd15, 0, 1), 1'b0, ST_OK},
      '{mk_req(K_DEL_P, 0, 3), 1'b0, ST_OK},
      '{mk_req(K_DEL_B, 0, 1), 1'b0, ST_OK}
    };
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].has_exp)
        typed_rsp.push_back(mk_rsp(dir_rows[i].exp_status, 0, 0, 1));
      send_request(dir_rows[i].req, 1'b1);
      // Let the typed answer line up with its request before moving on.
      in_valid <= 1'b0;
      @(negedge clk);
      while (pending_rsp.size() != 0) @(negedge clk);
    end
    // Fill to capacity, hit the full case, then force the output to stall.
    while (shadow_list.size() < CAP) send_request(mk_req(K_INS_B, $urandom(), 1), 1'b0);
    send_request(mk_req(K_INS_F, 1, 1), 1'b0);
    hold_off_req = 1'b1;
    send_request(mk_req(K_DUMP_F, 0, 1), 1'b0);
    send_request(mk_req(K_DUMP_R, 0, 1), 1'b0);
    send_request(mk_req(K_SRCH, shadow_list[CAP - 1], 1), 1'b0);
    send_request(mk_req(K_DEL_P, 0, CAP), 1'b0);
    // Random part; the last stretch runs with no idling.
    for (int i = 0; i < 200; i++) begin
      if (i == 170) quiet_phase = 1'b1;
      rq = rand_req();
      send_request(rq, 1'b1);
    end
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (pending_rsp.size() != 0 && wait_cycles < 100000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (50) @(negedge clk);
    $display("covered %0d requests and %0d results, all kinds, full and empty list",
             req_count, rsp_count);
    if (mismatch_count == 0 && pending_rsp.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count, pending_rsp.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/dlle_pkg.sv
rtl/doubly_linked_list_engine.sv
tb/testbench.sv
